>>> rtl/dda_pkg.sv
// Shared types and constants for the DDA line rasteriser.
// Depends on nothing; imported by the front, divider, back and top level.
package dda_pkg;

  // Depth of the item queue and of the result queue (a power of two)
  localparam int QUEUE_DEPTH = 2;
  localparam int PTR_BITS    = $clog2(QUEUE_DEPTH);
  localparam int CNT_BITS    = $clog2(QUEUE_DEPTH + 1);

  // Item kind, taken straight from the func field
  typedef enum logic {
    KIND_LOAD = 1'b0,
    KIND_STEP = 1'b1
  } kind_e;

  // Head of the item queue as the back end sees it
  typedef struct packed {
    logic  valid;
    kind_e kind;
  } head_t;

  // Divider status towards the back end
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

>>> rtl/dda_front.sv
// Front end of the DDA line rasteriser: accepts words, classifies them and
// prepares load deltas, then queues them for the back end. Uses dda_pkg.
module dda_front #(
  parameter int COORD_BITS = 10
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  logic                  func,
  input  logic [COORD_BITS-1:0] x_start,
  input  logic [COORD_BITS-1:0] y_start,
  input  logic [COORD_BITS-1:0] x_end,
  input  logic [COORD_BITS-1:0] y_end,
  output logic                  full,
  output dda_pkg::head_t        head,
  output logic [COORD_BITS-1:0] head_x_start,
  output logic [COORD_BITS-1:0] head_y_start,
  output logic [COORD_BITS-1:0] head_adx,
  output logic [COORD_BITS-1:0] head_ady,
  output logic [COORD_BITS-1:0] head_steps,
  output logic                  head_x_neg,
  output logic                  head_y_neg,
  input  logic                  take
);
  import dda_pkg::*;

  localparam int EW = 5 * COORD_BITS + 3;

  logic [EW-1:0]         mem [QUEUE_DEPTH];
  logic [PTR_BITS-1:0]   wptr;
  logic [PTR_BITS-1:0]   rptr;
  logic [CNT_BITS-1:0]   count;
  logic                  accept;
  logic                  drain;
  logic [COORD_BITS-1:0] adx;
  logic [COORD_BITS-1:0] ady;
  logic                  x_neg;
  logic                  y_neg;
  logic [COORD_BITS-1:0] steps;
  logic [EW-1:0]         entry;
  logic [EW-1:0]         rd;

  assign full   = (count == CNT_BITS'(QUEUE_DEPTH));
  assign accept = push && !full;
  assign drain  = take && (count != '0);

  // Classify and prepare deltas: magnitudes, directions and step count
  always_comb begin
    x_neg = (x_end < x_start);
    y_neg = (y_end < y_start);
    adx   = x_neg ? (x_start - x_end) : (x_end - x_start);
    ady   = y_neg ? (y_start - y_end) : (y_end - y_start);
    steps = (adx >= ady) ? adx : ady;
    entry = {func, x_start, y_start, adx, ady, steps, x_neg, y_neg};
  end

  // Store the word
  always_ff @(posedge clk) begin
    if (accept) begin
      mem[wptr] <= entry;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (accept) wptr <= wptr + PTR_BITS'(1);
      if (drain)  rptr <= rptr + PTR_BITS'(1);
      if (accept && !drain) begin
        count <= count + CNT_BITS'(1);
      end else if (drain && !accept) begin
        count <= count - CNT_BITS'(1);
      end
    end
  end

  // Present the oldest word
  always_comb begin
    rd           = mem[rptr];
    head.valid   = (count != '0);
    head.kind    = kind_e'(rd[EW-1]);
    head_x_start = rd[EW-2 -: COORD_BITS];
    head_y_start = rd[EW-2-COORD_BITS -: COORD_BITS];
    head_adx     = rd[EW-2-2*COORD_BITS -: COORD_BITS];
    head_ady     = rd[EW-2-3*COORD_BITS -: COORD_BITS];
    head_steps   = rd[EW-2-4*COORD_BITS -: COORD_BITS];
    head_x_neg   = rd[1];
    head_y_neg   = rd[0];
  end

endmodule

>>> rtl/dda_div.sv
// Increment divider: one restoring quotient bit per cycle for x and y at once,
// giving d * 2^FRAC_BITS / steps rounded toward plus infinity. Uses dda_pkg.
module dda_div #(
  parameter int COORD_BITS = 10,
  parameter int FRAC_BITS  = 24
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [COORD_BITS-1:0] steps,
  input  logic [COORD_BITS-1:0] adx,
  input  logic [COORD_BITS-1:0] ady,
  input  logic                  x_neg,
  input  logic                  y_neg,
  output dda_pkg::div_stat_t    stat,
  output logic [FRAC_BITS+1:0]  x_step,
  output logic [FRAC_BITS+1:0]  y_step
);
  import dda_pkg::*;

  localparam int IT_BITS = $clog2(FRAC_BITS + 2);

  logic [COORD_BITS-1:0] divisor;
  logic [COORD_BITS:0]   rx;
  logic [COORD_BITS:0]   ry;
  logic [FRAC_BITS:0]    qx;
  logic [FRAC_BITS:0]    qy;
  logic                  neg_x;
  logic                  neg_y;
  logic                  zero;
  logic [IT_BITS-1:0]    iter;
  logic                  busy;
  logic                  done;
  logic                  bit_x;
  logic                  bit_y;
  logic [COORD_BITS:0]   rx_sub;
  logic [COORD_BITS:0]   ry_sub;
  logic [FRAC_BITS+1:0]  ux;
  logic [FRAC_BITS+1:0]  uy;

  // Compare and subtract for this quotient bit
  always_comb begin
    bit_x  = (rx >= {1'b0, divisor});
    bit_y  = (ry >= {1'b0, divisor});
    rx_sub = rx - (bit_x ? {1'b0, divisor} : '0);
    ry_sub = ry - (bit_y ? {1'b0, divisor} : '0);
  end

  // Operand and remainder registers
  always_ff @(posedge clk) begin
    if (start) begin
      divisor <= steps;
      rx      <= {1'b0, adx};
      ry      <= {1'b0, ady};
      qx      <= '0;
      qy      <= '0;
      neg_x   <= x_neg;
      neg_y   <= y_neg;
      zero    <= (steps == '0);
    end else if (busy) begin
      rx <= {rx_sub[COORD_BITS-1:0], 1'b0};
      ry <= {ry_sub[COORD_BITS-1:0], 1'b0};
      qx <= {qx[FRAC_BITS-1:0], bit_x};
      qy <= {qy[FRAC_BITS-1:0], bit_y};
    end
  end

  // Iteration count: one integer bit and FRAC_BITS fraction bits
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      iter <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        iter <= IT_BITS'(FRAC_BITS + 1);
      end else if (busy) begin
        iter <= iter - IT_BITS'(1);
        if (iter == IT_BITS'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Sign and round: a positive ratio rounds up on a non-zero remainder
  always_comb begin
    ux = {1'b0, qx};
    uy = {1'b0, qy};
    if (zero) begin
      x_step = '0;
      y_step = '0;
    end else begin
      x_step = neg_x ? (~ux + (FRAC_BITS+2)'(1))
                     : (ux + (FRAC_BITS+2)'(rx != '0));
      y_step = neg_y ? (~uy + (FRAC_BITS+2)'(1))
                     : (uy + (FRAC_BITS+2)'(ry != '0));
    end
    stat.busy = busy;
    stat.done = done;
  end

endmodule

>>> rtl/dda_back.sv
// Back end of the DDA line rasteriser: runs line loads through the divider,
// steps the accumulators and queues result words. Uses dda_pkg and dda_div.
module dda_back #(
  parameter int COORD_BITS = 10,
  parameter int FRAC_BITS  = 24
) (
  input  logic                  clk,
  input  logic                  rst,
  input  dda_pkg::head_t        head,
  input  logic [COORD_BITS-1:0] head_x_start,
  input  logic [COORD_BITS-1:0] head_y_start,
  input  logic [COORD_BITS-1:0] head_adx,
  input  logic [COORD_BITS-1:0] head_ady,
  input  logic [COORD_BITS-1:0] head_steps,
  input  logic                  head_x_neg,
  input  logic                  head_y_neg,
  output logic                  take,
  output logic                  empty,
  input  logic                  pop,
  output logic [COORD_BITS-1:0] px,
  output logic [COORD_BITS-1:0] py,
  output logic                  last
);
  import dda_pkg::*;

  localparam int AW = COORD_BITS + 1 + FRAC_BITS;
  localparam int SW = FRAC_BITS + 2;
  localparam int OW = 2 * COORD_BITS + 1;

  typedef enum logic [1:0] {
    ST_READY = 2'b01,
    ST_DIV   = 2'b10
  } state_t;

  state_t              state;
  state_t              state_next;
  logic                active;
  logic [AW-1:0]       x_acc;
  logic [AW-1:0]       y_acc;
  logic [SW-1:0]       x_step;
  logic [SW-1:0]       y_step;
  logic [COORD_BITS:0] points_left;
  div_stat_t           dstat;
  logic [SW-1:0]       div_x;
  logic [SW-1:0]       div_y;
  logic                start;
  logic                emit;
  logic                oq_full;
  logic                oq_take;
  logic [OW-1:0]       oq_mem [QUEUE_DEPTH];
  logic [PTR_BITS-1:0] oq_wptr;
  logic [PTR_BITS-1:0] oq_rptr;
  logic [CNT_BITS-1:0] oq_count;
  logic [OW-1:0]       word;

  dda_div #(
    .COORD_BITS(COORD_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .steps (head_steps),
    .adx   (head_adx),
    .ady   (head_ady),
    .x_neg (head_x_neg),
    .y_neg (head_y_neg),
    .stat  (dstat),
    .x_step(div_x),
    .y_step(div_y)
  );

  assign oq_full = (oq_count == CNT_BITS'(QUEUE_DEPTH));

  // Decide what to do with the head word
  always_comb begin
    start      = 1'b0;
    emit       = 1'b0;
    take       = 1'b0;
    state_next = state;
    unique case (state)
      ST_READY: begin
        if (head.valid && head.kind == KIND_LOAD) begin
          start      = 1'b1;
          take       = 1'b1;
          state_next = ST_DIV;
        end else if (head.valid && head.kind == KIND_STEP) begin
          // drop steps with no line; otherwise wait for result room
          if (!active) begin
            take = 1'b1;
          end else if (!oq_full) begin
            take = 1'b1;
            emit = 1'b1;
          end
        end
      end
      ST_DIV: begin
        if (dstat.done) state_next = ST_READY;
      end
      default: state_next = ST_READY;
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_READY;
      active      <= 1'b0;
      points_left <= '0;
    end else begin
      state <= state_next;
      if (start) begin
        active      <= 1'b0;
        points_left <= {1'b0, head_steps} + (COORD_BITS+1)'(1);
      end else if (state == ST_DIV && dstat.done) begin
        active <= 1'b1;
      end else if (emit) begin
        points_left <= points_left - (COORD_BITS+1)'(1);
        if (points_left == (COORD_BITS+1)'(1)) active <= 1'b0;
      end
    end
  end

  // Accumulators and increments
  always_ff @(posedge clk) begin
    if (start) begin
      x_acc <= {1'b0, head_x_start, FRAC_BITS'(0)};
      y_acc <= {1'b0, head_y_start, FRAC_BITS'(0)};
    end else if (emit) begin
      x_acc <= x_acc + {{(AW-SW){x_step[SW-1]}}, x_step};
      y_acc <= y_acc + {{(AW-SW){y_step[SW-1]}}, y_step};
    end
    if (state == ST_DIV && dstat.done) begin
      x_step <= div_x;
      y_step <= div_y;
    end
  end

  // Result queue: floor of the accumulators, wrapped to the coordinate width
  assign word    = {x_acc[FRAC_BITS+COORD_BITS-1:FRAC_BITS],
                    y_acc[FRAC_BITS+COORD_BITS-1:FRAC_BITS],
                    (points_left == (COORD_BITS+1)'(1))};
  assign oq_take = pop && (oq_count != '0);

  always_ff @(posedge clk) begin
    if (emit) begin
      oq_mem[oq_wptr] <= word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      oq_wptr  <= '0;
      oq_rptr  <= '0;
      oq_count <= '0;
    end else begin
      if (emit)    oq_wptr <= oq_wptr + PTR_BITS'(1);
      if (oq_take) oq_rptr <= oq_rptr + PTR_BITS'(1);
      if (emit && !oq_take) begin
        oq_count <= oq_count + CNT_BITS'(1);
      end else if (oq_take && !emit) begin
        oq_count <= oq_count - CNT_BITS'(1);
      end
    end
  end

  assign empty             = (oq_count == '0);
  assign {px, py, last}    = oq_mem[oq_rptr];

endmodule

>>> rtl/dda_line_rasterizer.sv
// DDA line rasteriser, top level.
// Input channel (push/full): a word with func = 0 loads a line from
// (x_start, y_start) to (x_end, y_end); func = 1 asks for the next point.
// Result channel (empty/pop): px, py and last of the oldest waiting point.
// A line of steps = max(|dx|, |dy|) gives steps+1 points, one per step word;
// step words with no active line give nothing.
// Throughput: one step word per cycle while the result queue has room. A load
// occupies the back end until the divider is done; the divider forms one
// quotient bit a cycle for x and y together, and a two-word queue in front
// keeps accepting meanwhile. A point passes through the item queue and then
// the result queue, both registered, before it is on the result ports.
// Reset (rst, synchronous): both queues empty, no line active.
// When the receiver stalls, the two-word result queue fills, step words
// wait in the item queue, and full rises once that queue is full as well.
module dda_line_rasterizer #(
  parameter int COORD_BITS = 10,
  parameter int FRAC_BITS  = 24
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  output logic                  full,
  input  logic                  func,
  input  logic [COORD_BITS-1:0] x_start,
  input  logic [COORD_BITS-1:0] y_start,
  input  logic [COORD_BITS-1:0] x_end,
  input  logic [COORD_BITS-1:0] y_end,
  output logic                  empty,
  input  logic                  pop,
  output logic [COORD_BITS-1:0] px,
  output logic [COORD_BITS-1:0] py,
  output logic                  last
);
  import dda_pkg::*;

  head_t                 head;
  logic [COORD_BITS-1:0] head_x_start;
  logic [COORD_BITS-1:0] head_y_start;
  logic [COORD_BITS-1:0] head_adx;
  logic [COORD_BITS-1:0] head_ady;
  logic [COORD_BITS-1:0] head_steps;
  logic                  head_x_neg;
  logic                  head_y_neg;
  logic                  take;

  // Accept and classify
  dda_front #(
    .COORD_BITS(COORD_BITS)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .func        (func),
    .x_start     (x_start),
    .y_start     (y_start),
    .x_end       (x_end),
    .y_end       (y_end),
    .full        (full),
    .head        (head),
    .head_x_start(head_x_start),
    .head_y_start(head_y_start),
    .head_adx    (head_adx),
    .head_ady    (head_ady),
    .head_steps  (head_steps),
    .head_x_neg  (head_x_neg),
    .head_y_neg  (head_y_neg),
    .take        (take)
  );

  // Divide, step and queue results
  dda_back #(
    .COORD_BITS(COORD_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .head        (head),
    .head_x_start(head_x_start),
    .head_y_start(head_y_start),
    .head_adx    (head_adx),
    .head_ady    (head_ady),
    .head_steps  (head_steps),
    .head_x_neg  (head_x_neg),
    .head_y_neg  (head_y_neg),
    .take        (take),
    .empty       (empty),
    .pop         (pop),
    .px          (px),
    .py          (py),
    .last        (last)
  );

endmodule
